@@ hw/rtl/ets_pkg.sv @@
// Shared types, token codes and character classes for the expression token scanner.
package ets_pkg;

	localparam int unsigned KIND_W = 4;
	localparam int unsigned FIELD_W = 16;

	localparam logic [KIND_W-1:0] KIND_ERROR = 4'd0;
	localparam logic [KIND_W-1:0] KIND_END = 4'd1;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 4'd2;
	localparam logic [KIND_W-1:0] KIND_IDENT = 4'd3;
	localparam logic [KIND_W-1:0] KIND_PLUS = 4'd4;
	localparam logic [KIND_W-1:0] KIND_MINUS = 4'd5;
	localparam logic [KIND_W-1:0] KIND_STAR = 4'd6;
	localparam logic [KIND_W-1:0] KIND_SLASH = 4'd7;
	localparam logic [KIND_W-1:0] KIND_CARET = 4'd8;
	localparam logic [KIND_W-1:0] KIND_OPEN = 4'd9;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 4'd10;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LZ = 8'h7A;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UZ = 8'h5A;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [FIELD_W-1:0] start;
		logic [FIELD_W-1:0] length;
		logic               last;
	} ets_result_t;

	// up to two results from one byte, packed toward slot0
	typedef struct packed {
		logic [1:0]  cnt;
		ets_result_t slot0;
		ets_result_t slot1;
	} ets_burst_t;

	function automatic logic is_decimal(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_word_head(input logic [7:0] c);
		return ((c >= CH_LA) && (c <= CH_LZ)) || ((c >= CH_UA) && (c <= CH_UZ)) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
	endfunction

	function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		case (c)
			CH_PLUS:  k = KIND_PLUS;
			CH_MINUS: k = KIND_MINUS;
			CH_STAR:  k = KIND_STAR;
			CH_SLASH: k = KIND_SLASH;
			CH_CARET: k = KIND_CARET;
			CH_OPEN:  k = KIND_OPEN;
			CH_CLOSE: k = KIND_CLOSE;
			default:  k = KIND_ERROR;
		endcase
		return k;
	endfunction

endpackage

@@ hw/rtl/ets_scan.sv @@
// Scan state, byte classification and token formation for one byte a cycle while adv is high.
module ets_scan #(
	parameter int unsigned MAX_TEXT_LENGTH = 65535
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic [7:0]         text_byte,
	output ets_pkg::ets_burst_t burst
);

	localparam int unsigned POS_W = $clog2(MAX_TEXT_LENGTH + 1);
	localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_TEXT_LENGTH);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_INT,
		MODE_FRAC,
		MODE_IDENT
	} mode_t;

	mode_t            mode_q, mode_d;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pend_q, pend_d;
	logic [POS_W-1:0] len_full;
	logic [15:0]      pos16, pend16, len16;
	logic             cont;
	logic             flush_v, cur_v;
	ets_pkg::ets_result_t flush_r, cur_r;

	assign len_full = pos_q - pend_q;

	if (POS_W >= 16) begin : g_trunc
		assign pos16 = pos_q[15:0];
		assign pend16 = pend_q[15:0];
		assign len16 = len_full[15:0];
	end else begin : g_ext
		assign pos16 = {{(16 - POS_W){1'b0}}, pos_q};
		assign pend16 = {{(16 - POS_W){1'b0}}, pend_q};
		assign len16 = {{(16 - POS_W){1'b0}}, len_full};
	end

	always_comb begin
		cont = 1'b0;
		mode_d = mode_q;
		pend_d = pend_q;
		case (mode_q)
			MODE_INT: begin
				if (ets_pkg::is_decimal(text_byte)) begin
					cont = 1'b1;
				end else if (text_byte == ets_pkg::CH_DOT) begin
					cont = 1'b1;
					mode_d = MODE_FRAC;
				end
			end
			MODE_FRAC: cont = ets_pkg::is_decimal(text_byte);
			MODE_IDENT: cont = ets_pkg::is_word_head(text_byte) || ets_pkg::is_decimal(text_byte);
			default: cont = 1'b0;
		endcase

		flush_v = !cont && (mode_q != MODE_IDLE);
		flush_r.kind = (mode_q == MODE_IDENT) ? ets_pkg::KIND_IDENT : ets_pkg::KIND_NUMBER;
		flush_r.start = pend16;
		flush_r.length = len16;
		flush_r.last = 1'b0;

		cur_v = 1'b0;
		cur_r.kind = ets_pkg::single_kind(text_byte);
		cur_r.start = pos16;
		cur_r.length = 16'd1;
		cur_r.last = 1'b1;

		if (!cont) begin
			mode_d = MODE_IDLE;
			if (text_byte == ets_pkg::CH_NUL) begin
				cur_v = 1'b1;
				cur_r.kind = ets_pkg::KIND_END;
				cur_r.length = 16'd0;
			end else if (ets_pkg::is_space(text_byte)) begin
				cur_v = 1'b0;
			end else if (ets_pkg::is_decimal(text_byte)) begin
				mode_d = MODE_INT;
				pend_d = pos_q;
			end else if (ets_pkg::is_word_head(text_byte)) begin
				mode_d = MODE_IDENT;
				pend_d = pos_q;
			end else begin
				cur_v = 1'b1;
			end
		end

		// compact: the flushed token goes first
		burst.slot1 = cur_r;
		if (flush_v) begin
			burst.slot0 = flush_r;
			burst.slot0.last = !cur_v;
		end else begin
			burst.slot0 = cur_r;
		end
		burst.cnt = {1'b0, flush_v} + {1'b0, cur_v};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			pos_q <= '0;
			pend_q <= '0;
		end else if (adv) begin
			mode_q <= mode_d;
			if (text_byte == ets_pkg::CH_NUL) begin
				pos_q <= '0;
				pend_q <= '0;
			end else begin
				pend_q <= pend_d;
				if (pos_q < MAX_POS) begin
					pos_q <= pos_q + 1'b1;
				end
			end
		end
	end

endmodule

@@ hw/rtl/ets_queue.sv @@
// Four-entry result queue: takes up to two results a cycle, hands out one per beat.
module ets_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_en,
	input  ets_pkg::ets_burst_t  burst,
	output logic                 space2,
	output logic                 head_valid,
	input  logic                 head_pop,
	output ets_pkg::ets_result_t head
);

	ets_pkg::ets_result_t mem [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] count_q;
	logic [1:0] push_cnt;
	logic       pop;

	assign space2 = (count_q <= 3'd2);
	assign head_valid = (count_q != 3'd0);
	assign head = mem[rd_q];
	assign pop = head_valid && head_pop;
	assign push_cnt = push_en ? burst.cnt : 2'd0;

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			mem[wr_q] <= burst.slot0;
		end
		if (push_cnt == 2'd2) begin
			mem[wr_q + 2'd1] <= burst.slot1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			wr_q <= wr_q + push_cnt;
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push_cnt} - {2'b0, pop};
		end
	end

endmodule

@@ hw/rtl/expression_token_scanner_core.sv @@
// A byte accepted on s_axis is held in the input stage, scanned there once the queue has room
// for two results, and its tokens are registered into the result queue that drives m_axis.
// Throughput: one byte per cycle while each byte yields at most one token and m_axis is not
// held off; a byte that flushes a pending token and makes one of its own needs two output
// beats, so the single-beat output port sets the sustained rate.
// Reset (arst_n low, asynchronous): scanner idle, offsets zero, input stage and queue empty.
module expression_token_scanner_core #(
	parameter int unsigned MAX_TEXT_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // [3:0] token_kind, [19:4] token_start,
	                                    // [35:20] token_length, [39:36] zero
	output logic        m_axis_tlast    // last_of_run
);

	// input stage: one byte held while the queue lacks room for two results
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       adv;
	logic       space2;

	ets_pkg::ets_burst_t  burst;
	ets_pkg::ets_result_t head;

	// scan the held byte only when both worst-case results fit
	assign adv = valid_s1 && space2;
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload: load on every beat taken
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	ets_scan #(
		.MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.text_byte(byte_s1),
		.burst    (burst)
	);

	// result queue parts the scanner from output back-pressure
	ets_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (adv),
		.burst     (burst),
		.space2    (space2),
		.head_valid(m_axis_tvalid),
		.head_pop  (m_axis_tready),
		.head      (head)
	);

	assign m_axis_tdata = {4'b0, head.length, head.start, head.kind};
	assign m_axis_tlast = head.last;

endmodule

@@ test/expression_token_scanner_core_check.sv @@
// Token checker for the expression scanner: predicts tokens per accepted byte and compares beats.
`timescale 1ns / 1ps

module expression_token_scanner_core_check #(
	parameter int unsigned MAX_TEXT_LENGTH = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [39:0] m_axis_tdata,
	input  logic        m_axis_tlast,
	output int          mismatches,
	output int          tokens_due
);
	import ets_pkg::*;

	typedef enum logic [1:0] {SCAN_IDLE, SCAN_INT, SCAN_FRAC, SCAN_WORD} scan_state_t;
	typedef enum logic [2:0] {
		CLS_NUL, CLS_SPACE, CLS_DIGIT, CLS_DOT, CLS_WORD, CLS_OTHER
	} char_class_t;

	scan_state_t scan_state = SCAN_IDLE;
	int unsigned offset = 0;
	int unsigned token_origin = 0;
	ets_result_t token_q[$];
	ets_result_t oldest;
	int fail_count = 0;
	int due_count = 0;

	assign mismatches = fail_count;
	assign tokens_due = due_count;

	function automatic char_class_t classify(input logic [7:0] c);
		if (c == CH_NUL)
			return CLS_NUL;
		if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)
			return CLS_SPACE;
		if (c >= CH_0 && c <= CH_9)
			return CLS_DIGIT;
		if (c == CH_DOT)
			return CLS_DOT;
		if ((c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER)
			return CLS_WORD;
		return CLS_OTHER;
	endfunction

	function automatic logic [KIND_W-1:0] operator_kind(input logic [7:0] c);
		case (c)
			CH_PLUS:  return KIND_PLUS;
			CH_MINUS: return KIND_MINUS;
			CH_STAR:  return KIND_STAR;
			CH_SLASH: return KIND_SLASH;
			CH_CARET: return KIND_CARET;
			CH_OPEN:  return KIND_OPEN;
			CH_CLOSE: return KIND_CLOSE;
			default:  return KIND_ERROR;
		endcase
	endfunction

	function automatic ets_result_t make_token(input logic [KIND_W-1:0] kind,
			input int unsigned start, input int unsigned len);
		ets_result_t r;
		r.kind = kind;
		r.start = 16'(start);
		r.length = 16'(len);
		r.last = 1'b0;
		return r;
	endfunction

	// advance the scanner by one byte and queue the tokens it yields
	task automatic scan_byte(input logic [7:0] c);
		char_class_t cls;
		logic absorbed;
		ets_result_t burst [0:1];
		int n;
		int unsigned here;
		cls = classify(c);
		here = offset;
		n = 0;
		absorbed = 1'b0;
		case (scan_state)
			SCAN_INT: begin
				if (cls == CLS_DIGIT) begin
					absorbed = 1'b1;
				end else if (cls == CLS_DOT) begin
					scan_state = SCAN_FRAC;
					absorbed = 1'b1;
				end
			end
			SCAN_FRAC: absorbed = (cls == CLS_DIGIT);
			SCAN_WORD: absorbed = (cls == CLS_WORD) || (cls == CLS_DIGIT);
			default: ;
		endcase
		if (!absorbed) begin
			if (scan_state != SCAN_IDLE) begin
				burst[n] = make_token(scan_state == SCAN_WORD ? KIND_IDENT : KIND_NUMBER,
					token_origin, here >= token_origin ? here - token_origin : 0);
				n++;
				scan_state = SCAN_IDLE;
			end
			case (cls)
				CLS_NUL: begin
					burst[n] = make_token(KIND_END, here, 0);
					n++;
				end
				CLS_SPACE: ;
				CLS_DIGIT: begin
					scan_state = SCAN_INT;
					token_origin = here;
				end
				CLS_WORD: begin
					scan_state = SCAN_WORD;
					token_origin = here;
				end
				default: begin
					burst[n] = make_token(operator_kind(c), here, 1);
					n++;
				end
			endcase
		end
		if (cls == CLS_NUL) begin
			offset = 0;
			token_origin = 0;
		end else if (offset < MAX_TEXT_LENGTH) begin
			offset = offset + 1;
		end
		if (n > 0)
			burst[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			token_q.push_back(burst[i]);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_state = SCAN_IDLE;
			offset = 0;
			token_origin = 0;
			token_q.delete();
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				scan_byte(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (token_q.size() == 0) begin
					$error("unexpected token beat: tdata %h, tlast %b",
						m_axis_tdata, m_axis_tlast);
					fail_count++;
				end else begin
					oldest = token_q.pop_front();
					check_field("token_kind", oldest.kind, m_axis_tdata[3:0]);
					check_field("token_start", oldest.start, m_axis_tdata[19:4]);
					check_field("token_length", oldest.length, m_axis_tdata[35:20]);
					check_field("last_of_run", oldest.last, m_axis_tlast);
					check_field("tdata padding", 0, m_axis_tdata[39:36]);
				end
			end
		end
		due_count = token_q.size();
	end

endmodule

@@ test/expression_token_scanner_core_test.sv @@
// Testbench top for the expression scanner: byte stimulus, token sink, watchdog and verdict.
`timescale 1ns / 1ps

module expression_token_scanner_core_test;
	import ets_pkg::*;

	localparam int unsigned TEXT_LIMIT = 65535;
	// no beat on either side for this many cycles means the block is stuck
	localparam int STALL_LIMIT = 1000;
	// cycles to watch for stray tokens once everything expected has arrived
	localparam int TAIL_CYCLES = 16;
	localparam int RANDOM_BYTES = 140;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tlast;

	int mismatches;
	int tokens_due;
	int quiet_cycles = 0;
	int random_bytes = 0;

	// idling switches, cleared for stretches that run back to back
	logic tx_idles = 1'b1;
	logic rx_idles = 1'b1;

	expression_token_scanner_core #(
		.MAX_TEXT_LENGTH(TEXT_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	expression_token_scanner_core_check #(
		.MAX_TEXT_LENGTH(TEXT_LIMIT)
	) token_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast),
		.mismatches(mismatches),
		.tokens_due(tokens_due)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Offer one byte and hold it until the block takes it. An idle gap drops
	// tvalid first; with no gap tvalid stays high and only the data moves on.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_idles ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Hold off the input until every predicted token has come out. Sample the
	// checker's count on the falling edge, then resume on a rising one.
	task automatic drain_tokens();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (tokens_due != 0) @(negedge clk);
		@(posedge clk);
	endtask

	function automatic logic [7:0] pick_digit();
		return CH_0 + 8'($urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] pick_word_head();
		int r;
		r = $urandom_range(0, 52);
		if (r < 26)
			return CH_LA + 8'(r);
		if (r < 52)
			return CH_UA + 8'(r - 26);
		return CH_UNDER;
	endfunction

	function automatic logic [7:0] pick_operator();
		case ($urandom_range(0, 6))
			0: return CH_PLUS;
			1: return CH_MINUS;
			2: return CH_STAR;
			3: return CH_SLASH;
			4: return CH_CARET;
			5: return CH_OPEN;
			default: return CH_CLOSE;
		endcase
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
			0: return CH_SPACE;
			1: return CH_TAB;
			2: return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// Send one expression closed by the terminator. Most are well formed
	// (numbers, names, operators, blanks, a stray byte now and then); some
	// are raw noise over the full byte range, zero bytes included.
	task automatic send_expression();
		int parts;
		int pick;
		int reps;
		if ($urandom_range(0, 5) == 0) begin
			reps = $urandom_range(1, 10);
			repeat (reps) begin
				send_byte(8'($urandom_range(0, 255)));
				random_bytes++;
			end
		end else begin
			parts = $urandom_range(0, 8);
			repeat (parts) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					reps = $urandom_range(1, 4);
					repeat (reps) begin
						send_byte(pick_digit());
						random_bytes++;
					end
					if ($urandom_range(0, 2) == 0) begin
						send_byte(CH_DOT);
						random_bytes++;
						reps = $urandom_range(0, 3);
						repeat (reps) begin
							send_byte(pick_digit());
							random_bytes++;
						end
					end
				end else if (pick < 55) begin
					send_byte(pick_word_head());
					random_bytes++;
					reps = $urandom_range(0, 4);
					repeat (reps) begin
						send_byte($urandom_range(0, 3) == 0 ? pick_digit() : pick_word_head());
						random_bytes++;
					end
				end else if (pick < 80) begin
					send_byte(pick_operator());
					random_bytes++;
				end else if (pick < 92) begin
					send_byte(pick_space());
					random_bytes++;
				end else begin
					send_byte(8'($urandom_range(1, 255)));
					random_bytes++;
				end
			end
		end
		send_byte(CH_NUL);
		random_bytes++;
	endtask

	// Token sink: draw an idle gap per beat, then hold tready until a beat lands.
	initial begin
		int gap;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_idles ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Watchdog: count cycles without a beat on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	initial begin
		string directed;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: fraction, name with digit, every operator, number running
		// into a name, a number ended by its dot, a second dot inside a
		// fraction, an error byte followed by blanks, a high byte, then two
		// terminators in a row with nothing pending.
		directed = "1.5+_Z9*(3x-7./2.3.4)^# \t\r\n";
		for (int i = 0; i < directed.len(); i++)
			send_byte(directed[i]);
		send_byte(8'hFF);
		send_byte(CH_NUL);
		send_byte(CH_NUL);
		drain_tokens();

		// Random expressions, some run back to back, with an occasional pause
		// until the output side has caught up.
		while (random_bytes < RANDOM_BYTES) begin
			tx_idles = ($urandom_range(0, 3) != 0);
			rx_idles = ($urandom_range(0, 3) != 0);
			send_expression();
			if ($urandom_range(0, 4) == 0)
				drain_tokens();
		end
		tx_idles = 1'b1;
		rx_idles = 1'b1;

		drain_tokens();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && tokens_due == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
